// ----- hw/rtl/mdrq_pkg.sv -----
`timescale 1ns / 1ps

package mdrq_pkg;

  // Ring sizes
  localparam int QUEUE_DEPTH = 64;
  localparam int DATA_BYTES  = 65536;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);

  // Field widths
  localparam int CMD_W = 3;
  localparam int ST_W  = 3;
  localparam int SRC_W = 16;
  localparam int TAG_W = 31;
  localparam int LEN_W = 17;
  localparam int OFF_W = 16;
  localparam int CNT_W = 7;

  localparam logic [LEN_W-1:0] DATA_BYTES_L     = LEN_W'(DATA_BYTES);
  localparam logic [CNT_W-1:0] QUEUE_DEPTH_L    = CNT_W'(QUEUE_DEPTH);
  localparam logic [QA_W-1:0]  QUEUE_LAST_L     = QA_W'(QUEUE_DEPTH - 1);
  localparam logic [LEN_W-1:0] THRESHOLD_RESET  = LEN_W'(49152);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_REQUEST = 3'd3,
    CMD_QUERY   = 3'd4
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_NOSPACE = 3'd3,
    ST_IGNORED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DROP
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [SRC_W-1:0] src_rank;
    logic [TAG_W-1:0] msg_tag;
    logic [LEN_W-1:0] msg_length;
    logic [CNT_W-1:0] clear_count;
  } in_word_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [SRC_W-1:0] out_src;
    logic [TAG_W-1:0] out_tag;
    logic [LEN_W-1:0] out_length;
    logic [OFF_W-1:0] data_offset;
    logic [LEN_W-1:0] pre_wrap_len;
    logic [CNT_W-1:0] entries;
    logic [LEN_W-1:0] bytes_used;
    logic             over_threshold;
  } out_word_t;

  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
    logic [OFF_W-1:0] off;
  } desc_t;

  typedef struct packed {
    logic            wr_en;
    logic [QA_W-1:0] wr_addr;
    desc_t           wr_data;
    logic [QA_W-1:0] rd_addr;
  } mem_req_t;

endpackage

// ----- hw/rtl/mdrq_desc_mem.sv -----
`timescale 1ns / 1ps

module mdrq_desc_mem
  import mdrq_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output desc_t    rd_data
);

  desc_t mem [QUEUE_DEPTH];

  // Write one descriptor per cycle
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Register read data (old data on a same-address write)
  always_ff @(posedge clk) begin
    rd_data <= mem[req.rd_addr];
  end

endmodule

// ----- hw/rtl/mdrq_ctrl.sv -----
`timescale 1ns / 1ps

module mdrq_ctrl
  import mdrq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  in_word_t         in_word,
  output logic             busy,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  output logic             out_valid,
  output out_word_t        out_word,
  output mem_req_t         mem_req,
  input  desc_t            rd_data
);

  state_t           state_r, state_nxt;
  in_word_t         in_r;
  logic [QA_W-1:0]  head_r, head_nxt;
  logic [QA_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0] entries_r, entries_nxt;
  logic [OFF_W-1:0] bhead_r, bhead_nxt;
  logic [OFF_W-1:0] btail_r, btail_nxt;
  logic [LEN_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] thr_r;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_r, out_nxt;

  logic             accept;
  logic [LEN_W-1:0] free_bytes;
  logic [LEN_W-1:0] room;
  logic [LEN_W-1:0] tail_sum;
  logic [LEN_W-1:0] head_sum;
  logic [OFF_W-1:0] tail_adv;
  logic [OFF_W-1:0] head_adv;
  logic [LEN_W-1:0] used_dec;
  logic [QA_W-1:0]  head_inc;
  logic [QA_W-1:0]  tail_inc;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // Byte ring arithmetic
  always_comb begin
    free_bytes = DATA_BYTES_L - used_r;
    room       = DATA_BYTES_L - {1'b0, btail_r};
    tail_sum   = {1'b0, btail_r} + in_r.msg_length;
    head_sum   = {1'b0, bhead_r} + rd_data.len;
    tail_adv   = (tail_sum >= DATA_BYTES_L) ? OFF_W'(tail_sum - DATA_BYTES_L)
                                            : OFF_W'(tail_sum);
    head_adv   = (head_sum >= DATA_BYTES_L) ? OFF_W'(head_sum - DATA_BYTES_L)
                                            : OFF_W'(head_sum);
    used_dec   = (rd_data.len > used_r) ? '0 : used_r - rd_data.len;
    head_inc   = (head_r == QUEUE_LAST_L) ? '0 : head_r + 1'b1;
    tail_inc   = (tail_r == QUEUE_LAST_L) ? '0 : tail_r + 1'b1;
  end

  // Next state, ring updates and result word
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    entries_nxt   = entries_r;
    bhead_nxt     = bhead_r;
    btail_nxt     = btail_r;
    used_nxt      = used_r;
    rem_nxt       = rem_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    mem_req       = '0;
    mem_req.wr_addr         = tail_r;
    mem_req.wr_data.src     = in_r.src_rank;
    mem_req.wr_data.tag     = in_r.msg_tag;
    mem_req.wr_data.len     = in_r.msg_length;
    mem_req.wr_data.off     = btail_r;
    out_nxt.status          = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        unique case (in_r.cmd)
          CMD_PUSH: begin
            if (entries_r >= QUEUE_DEPTH_L) begin
              out_nxt.status = ST_FULL;
            end else if (in_r.msg_length > free_bytes) begin
              out_nxt.status = ST_NOSPACE;
            end else begin
              mem_req.wr_en = 1'b1;
              btail_nxt     = tail_adv;
              tail_nxt      = tail_inc;
              used_nxt      = used_r + in_r.msg_length;
              entries_nxt   = entries_r + 1'b1;
            end
          end
          CMD_POP: begin
            if (entries_r == '0) begin
              out_nxt.status = ST_EMPTY;
            end else begin
              out_nxt.out_src     = rd_data.src;
              out_nxt.out_tag     = rd_data.tag;
              out_nxt.out_length  = rd_data.len;
              out_nxt.data_offset = rd_data.off;
              bhead_nxt           = head_adv;
              used_nxt            = used_dec;
              head_nxt            = head_inc;
              entries_nxt         = entries_r - 1'b1;
            end
          end
          CMD_CLEAR: begin
            if (in_r.clear_count == entries_r) begin
              head_nxt    = '0;
              tail_nxt    = '0;
              entries_nxt = '0;
              bhead_nxt   = '0;
              btail_nxt   = '0;
              used_nxt    = '0;
            end else if (in_r.clear_count < entries_r) begin
              // Walk the head entries before reporting
              out_valid_nxt = 1'b0;
              rem_nxt       = in_r.clear_count;
              state_nxt     = S_DROP;
            end else begin
              out_nxt.status = ST_IGNORED;
            end
          end
          CMD_REQUEST: begin
            if (in_r.msg_length > free_bytes) begin
              out_nxt.status = ST_NOSPACE;
            end else begin
              out_nxt.data_offset  = btail_r;
              out_nxt.pre_wrap_len = (room >= in_r.msg_length) ? in_r.msg_length : room;
            end
          end
          default: begin
          end
        endcase
      end

      S_DROP: begin
        if (rem_r == '0) begin
          // Head now points at the first kept entry
          bhead_nxt     = rd_data.off;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          used_nxt    = used_dec;
          head_nxt    = head_inc;
          entries_nxt = entries_r - 1'b1;
          rem_nxt     = rem_r - 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Read the entry the head will point at next cycle
    mem_req.rd_addr        = head_nxt;
    out_nxt.entries        = entries_nxt;
    out_nxt.bytes_used     = used_nxt;
    out_nxt.over_threshold = (used_nxt >= thr_r);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      entries_r   <= '0;
      bhead_r     <= '0;
      btail_r     <= '0;
      used_r      <= '0;
      rem_r       <= '0;
      thr_r       <= THRESHOLD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      entries_r   <= entries_nxt;
      bhead_r     <= bhead_nxt;
      btail_r     <= btail_nxt;
      used_r      <= used_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_word;
    end
    out_r <= out_nxt;
  end

`ifndef SYNTH
  a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entries_r <= QUEUE_DEPTH_L)
    else $error("descriptor count beyond queue depth");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= DATA_BYTES_L)
    else $error("used bytes beyond buffer size");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (entries_r == '0) |-> (head_r == tail_r))
    else $error("empty queue with head and tail apart");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted word did not start execution");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE) && ($past(state_r) != S_IDLE))
    else $error("result strobe without a finished command");
`endif

endmodule

// ----- hw/rtl/message_descriptor_ring_queue.sv -----
`timescale 1ns / 1ps

// Channel   Ports                              Direction  Handshake
// input     start, busy, in_word (in_word_t)  in         taken when start && !busy
// result    out_valid, out_word (out_word_t)  out        one-cycle strobe, no stall
// config    cfg_we, cfg_wdata                 in         written when cfg_we
//
// Push, pop, space request, status query, unused codes and a clear that empties the queue
// or is ignored: the accept edge reads the head descriptor, the next cycle updates the
// rings and registers the result, strobed the cycle after.
// A clear that drops N < count entries walks the head, one RAM read per drop
// plus one read of the new head offset. Reset (rst_n low, synchronous) empties both
// rings and sets the threshold to 49152; results cannot be held off by the receiver.

module message_descriptor_ring_queue
  import mdrq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_word_t         in_word,
  output logic             out_valid,
  output out_word_t        out_word,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  mem_req_t mem_req;
  desc_t    rd_data;

  mdrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_word   (in_word),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_word  (out_word),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  mdrq_desc_mem u_desc_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule

// ----- verif/tb_message_descriptor_ring_queue.sv -----
`timescale 1ns / 1ps

module tb_message_descriptor_ring_queue;
  import mdrq_pkg::*;

  // How a queued clear picks its count when it is launched
  typedef enum logic [1:0] {
    CLR_AS_GIVEN,
    CLR_ALL,
    CLR_SOME
  } clear_fit_t;

  typedef struct {
    in_word_t   w;
    clear_fit_t fit;
  } pending_cmd_t;

  localparam int CMD_LAST_CODE = (1 << CMD_W) - 1;
  localparam int MAX_REPORTS   = 10;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  in_word_t         in_word   = '0;
  logic             out_valid;
  out_word_t        out_word;
  logic             cfg_we    = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;

  message_descriptor_ring_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of both rings and the threshold register
  desc_t            slots [QUEUE_DEPTH];
  logic [QA_W-1:0]  q_head  = '0;
  logic [QA_W-1:0]  q_tail  = '0;
  logic [CNT_W-1:0] q_count = '0;
  logic [OFF_W-1:0] b_head  = '0;
  logic [OFF_W-1:0] b_tail  = '0;
  logic [LEN_W-1:0] b_used  = '0;
  logic [LEN_W-1:0] thr     = THRESHOLD_RESET;

  pending_cmd_t cmds_to_send [$];
  out_word_t    ring_results_due [$];
  pending_cmd_t next_cmd;
  out_word_t    due_word;
  int           send_idle_pct = 0;
  int           error_count   = 0;

  function automatic logic [QA_W-1:0] ring_next(logic [QA_W-1:0] idx);
    return (idx == QUEUE_LAST_L) ? '0 : idx + 1'b1;
  endfunction

  // Drop the head descriptor and free its bytes
  function automatic void free_head_slot();
    logic [LEN_W-1:0] l;
    l = slots[q_head].len;
    b_used  = (l > b_used) ? '0 : b_used - l;
    q_head  = ring_next(q_head);
    q_count = q_count - 1'b1;
  endfunction

  // Apply one command word to the shadow rings and return the word it reports
  function automatic out_word_t ring_result(in_word_t w);
    out_word_t r;
    int        free_b;
    int        room;
    int        i;
    r = '0;
    r.status = ST_OK;
    free_b = DATA_BYTES - int'(b_used);
    case (w.cmd)
      CMD_PUSH: begin
        if (q_count >= QUEUE_DEPTH_L) begin
          r.status = ST_FULL;
        end else if (int'(w.msg_length) > free_b) begin
          r.status = ST_NOSPACE;
        end else begin
          slots[q_tail] = '{src: w.src_rank, tag: w.msg_tag, len: w.msg_length, off: b_tail};
          b_tail  = OFF_W'((int'(b_tail) + int'(w.msg_length)) % DATA_BYTES);
          q_tail  = ring_next(q_tail);
          b_used  = b_used + w.msg_length;
          q_count = q_count + 1'b1;
        end
      end
      CMD_POP: begin
        if (q_count == '0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_src     = slots[q_head].src;
          r.out_tag     = slots[q_head].tag;
          r.out_length  = slots[q_head].len;
          r.data_offset = slots[q_head].off;
          b_head = OFF_W'((int'(b_head) + int'(slots[q_head].len)) % DATA_BYTES);
          free_head_slot();
        end
      end
      CMD_CLEAR: begin
        if (w.clear_count == q_count) begin
          q_head  = '0;
          q_tail  = '0;
          q_count = '0;
          b_head  = '0;
          b_tail  = '0;
          b_used  = '0;
        end else if (w.clear_count < q_count) begin
          for (i = 0; i < int'(w.clear_count); i++) free_head_slot();
          b_head = slots[q_head].off;
        end else begin
          r.status = ST_IGNORED;
        end
      end
      CMD_REQUEST: begin
        if (int'(w.msg_length) > free_b) begin
          r.status = ST_NOSPACE;
        end else begin
          room = DATA_BYTES - int'(b_tail);
          r.data_offset  = b_tail;
          r.pre_wrap_len = LEN_W'((room >= int'(w.msg_length)) ? int'(w.msg_length) : room);
        end
      end
      default: begin
        // status query and unused codes report occupancy only
      end
    endcase
    r.entries        = q_count;
    r.bytes_used     = b_used;
    r.over_threshold = (b_used >= thr);
    return r;
  endfunction

  // Drive command words: launch the next one once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) ring_results_due.push_back(ring_result(in_word));
      if (!start || !busy) begin
        if (cmds_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = cmds_to_send.pop_front();
          if (next_cmd.fit == CLR_ALL) begin
            next_cmd.w.clear_count = q_count;
          end else if (next_cmd.fit == CLR_SOME) begin
            next_cmd.w.clear_count = (q_count == '0) ? '0 :
                                     CNT_W'($urandom_range(int'(q_count) - 1));
          end
          in_word <= next_cmd.w;
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v)
      report_error($sformatf("%s expected 0x%0h got 0x%0h", name, exp_v, got_v));
  endtask

  // Check each result word against the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (ring_results_due.size() == 0) begin
        report_error($sformatf("result word 0x%0h with none due", out_word));
      end else begin
        due_word = ring_results_due.pop_front();
        check_field("status", due_word.status, out_word.status);
        check_field("out_src", due_word.out_src, out_word.out_src);
        check_field("out_tag", due_word.out_tag, out_word.out_tag);
        check_field("out_length", due_word.out_length, out_word.out_length);
        check_field("data_offset", due_word.data_offset, out_word.data_offset);
        check_field("pre_wrap_len", due_word.pre_wrap_len, out_word.pre_wrap_len);
        check_field("entries", due_word.entries, out_word.entries);
        check_field("bytes_used", due_word.bytes_used, out_word.bytes_used);
        check_field("over_threshold", due_word.over_threshold, out_word.over_threshold);
      end
    end
  end

  task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic [SRC_W-1:0] src,
                         input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len,
                         input logic [CNT_W-1:0] cnt, input clear_fit_t fit);
    pending_cmd_t p;
    p.w.cmd         = cmd;
    p.w.src_rank    = src;
    p.w.msg_tag     = tag;
    p.w.msg_length  = len;
    p.w.clear_count = cnt;
    p.fit           = fit;
    cmds_to_send.push_back(p);
  endtask

  // Mostly short messages so the queue fills; some large ones to run out of bytes
  function automatic logic [LEN_W-1:0] random_length();
    int r;
    r = $urandom_range(99);
    if (r < 55) return LEN_W'($urandom_range(2047));
    if (r < 80) return LEN_W'($urandom_range(16383));
    if (r < 93) return LEN_W'($urandom_range(DATA_BYTES - 1, 16384));
    if (r < 97) return DATA_BYTES_L;
    return '0;
  endfunction

  task automatic add_random(input int n);
    int         done;
    int         sel;
    int         j;
    clear_fit_t fit;
    done = 0;
    while (done < n) begin
      if ($urandom_range(99) < 3) begin
        // fill the descriptor queue past full with short pushes
        for (j = 0; j < QUEUE_DEPTH + 6; j++)
          add_cmd(CMD_PUSH, SRC_W'($urandom), TAG_W'($urandom),
                  LEN_W'($urandom_range(300)), CNT_W'($urandom_range(QUEUE_DEPTH)),
                  CLR_AS_GIVEN);
        done += QUEUE_DEPTH + 6;
      end else begin
        sel = $urandom_range(99);
        fit = CLR_AS_GIVEN;
        if (sel >= 65 && sel < 72) begin
          j = $urandom_range(99);
          fit = (j < 35) ? CLR_ALL : (j < 75) ? CLR_SOME : CLR_AS_GIVEN;
        end
        add_cmd((sel < 45) ? CMD_PUSH : (sel < 65) ? CMD_POP : (sel < 72) ? CMD_CLEAR :
                (sel < 87) ? CMD_REQUEST : (sel < 97) ? CMD_QUERY :
                CMD_W'($urandom_range(CMD_LAST_CODE, int'(CMD_QUERY) + 1)),
                SRC_W'($urandom), TAG_W'($urandom), random_length(),
                CNT_W'($urandom_range(QUEUE_DEPTH)), fit);
        done++;
      end
    end
  endtask

  // Wait until every word is sent and answered, then let the block settle
  task automatic drain();
    while (cmds_to_send.size() != 0 || start || ring_results_due.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    thr = v;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 17;

    // Directed: empty ring, byte extremes, wrap, every clear outcome, unused codes
    add_cmd(CMD_QUERY, '0, '0, '0, '0, CLR_AS_GIVEN);
    add_cmd(CMD_POP, '0, '0, '0, '0, CLR_AS_GIVEN);
    add_cmd(CMD_CLEAR, '0, '0, '0, '0, CLR_AS_GIVEN);
    add_cmd(CMD_CLEAR, '0, '0, '0, CNT_W'(5), CLR_AS_GIVEN);
    add_cmd(CMD_REQUEST, '0, '0, '0, '0, CLR_AS_GIVEN);
    add_cmd(CMD_REQUEST, '0, '0, DATA_BYTES_L, '0, CLR_AS_GIVEN);
    add_cmd(CMD_PUSH, '1, '1, DATA_BYTES_L, '1, CLR_AS_GIVEN);
    add_cmd(CMD_PUSH, '1, '0, '0, '0, CLR_AS_GIVEN);
    add_cmd(CMD_PUSH, '0, '1, LEN_W'(1), '0, CLR_AS_GIVEN);
    add_cmd(CMD_REQUEST, '0, '0, LEN_W'(1), '0, CLR_AS_GIVEN);
    add_cmd(CMD_POP, '0, '0, '0, '0, CLR_AS_GIVEN);
    add_cmd(CMD_POP, '0, '0, '0, '0, CLR_AS_GIVEN);
    add_cmd(CMD_POP, '0, '0, '0, '0, CLR_AS_GIVEN);
    add_cmd(CMD_PUSH, '0, '0, LEN_W'(60000), '0, CLR_AS_GIVEN);
    add_cmd(CMD_POP, '0, '0, '0, '0, CLR_AS_GIVEN);
    add_cmd(CMD_REQUEST, '0, '0, LEN_W'(10000), '0, CLR_AS_GIVEN);
    add_cmd(CMD_PUSH, SRC_W'(16'h1234), TAG_W'(1), LEN_W'(10000), '0, CLR_AS_GIVEN);
    add_cmd(CMD_CLEAR, '0, '0, '0, CNT_W'(1), CLR_AS_GIVEN);
    add_cmd(CMD_PUSH, SRC_W'(1), TAG_W'(2), LEN_W'(100), '0, CLR_AS_GIVEN);
    add_cmd(CMD_PUSH, SRC_W'(2), TAG_W'(3), LEN_W'(200), '0, CLR_AS_GIVEN);
    add_cmd(CMD_PUSH, SRC_W'(3), TAG_W'(4), LEN_W'(300), '0, CLR_AS_GIVEN);
    add_cmd(CMD_CLEAR, '0, '0, '0, CNT_W'(2), CLR_AS_GIVEN);
    add_cmd(CMD_CLEAR, '0, '0, '0, QUEUE_DEPTH_L, CLR_AS_GIVEN);
    add_cmd(CMD_CLEAR, '0, '0, '0, CNT_W'(1), CLR_AS_GIVEN);
    add_cmd(CMD_W'(int'(CMD_QUERY) + 1), '1, '1, DATA_BYTES_L, '1, CLR_AS_GIVEN);
    add_cmd(CMD_W'(CMD_LAST_CODE), '0, '0, '0, '0, CLR_AS_GIVEN);
    drain();

    // Random phases across threshold settings and sender pacing
    set_threshold('0);
    add_random(100);
    drain();
    set_threshold(DATA_BYTES_L);
    add_random(100);
    drain();
    send_idle_pct = 59;
    set_threshold(LEN_W'(1));
    add_random(100);
    drain();
    set_threshold(LEN_W'($urandom_range(DATA_BYTES)));
    add_random(100);
    drain();
    send_idle_pct = 0;
    set_threshold(LEN_W'(DATA_BYTES / 2));
    add_random(100);
    drain();

    if (ring_results_due.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/mdrq_pkg.sv
hw/rtl/mdrq_desc_mem.sv
hw/rtl/mdrq_ctrl.sv
hw/rtl/message_descriptor_ring_queue.sv
verif/tb_message_descriptor_ring_queue.sv
